// ----- rtl/wheel_encoder_odometry_macros.svh -----
// ----------------------------------------------------------------------------
// Wheel encoder odometry assertion macros
// Property shorthands for the top level, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef WHEEL_ENCODER_ODOMETRY_MACROS_SVH
`define WHEEL_ENCODER_ODOMETRY_MACROS_SVH

// same-cycle implication
`define WEO_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WEO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/weo_pkg.sv -----
// ----------------------------------------------------------------------------
// Wheel encoder odometry package
// Widths, register map, CORDIC table, controller states and command types.
// ----------------------------------------------------------------------------
package weo_pkg;

	localparam int DELTA_W   = 24;
	localparam int FGAIN_W   = 24;
	localparam int TGAIN_W   = 32;
	localparam int POS_W     = 32;
	localparam int ANG_W     = 32;
	localparam int APB_DW    = 32;
	localparam int APB_AW    = 3;

	// register indexes, selected by paddr[2]
	localparam logic REG_FORWARD_GAIN = 1'b0;
	localparam logic REG_TURN_GAIN    = 1'b1;

	localparam logic [FGAIN_W-1:0] FORWARD_GAIN_RST = 24'd168611;
	localparam logic [TGAIN_W-1:0] TURN_GAIN_RST    = 32'd241047738;

	localparam int FWD_PROD_W = FGAIN_W + 1 + DELTA_W + 1;
	localparam int TRN_PROD_W = TGAIN_W + 1 + DELTA_W + 1;
	localparam int DIST_W     = 30;
	localparam int INV_GAIN_W = 31;
	localparam int CX_PROD_W  = DIST_W + INV_GAIN_W;
	localparam int CORD_W     = 34;
	localparam int Z_W        = ANG_W + 1;
	localparam int SUM_W      = CORD_W + 1;
	localparam int CNT_W      = 5;

	localparam int FWD_RND     = 1 << 19;
	localparam int DTHETA_RND  = 1 << 15;
	localparam int HALF_RND    = 1 << 16;
	localparam int INV_GAIN    = 652032874;

	localparam logic [ANG_W-1:0] ATAN_TURNS [32] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
		32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
		32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
		32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
		32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
		32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
		32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
	};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCALE,
		ST_SEED,
		ST_ITER,
		ST_ACCUM,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic clear;
		logic scale;
		logic seed;
		logic iterate;
		logic accumulate;
		logic publish;
	} cmd_t;

	typedef struct packed {
		logic last_iter;
	} status_t;

	typedef struct packed {
		logic [FGAIN_W-1:0] forward_gain;
		logic [TGAIN_W-1:0] turn_gain;
	} cfg_t;

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic [ANG_W-1:0]        heading;
	} pose_t;

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(32'sh7FFF_FFFF);
		lo = -hi - SUM_W'(1);
		if (v > hi) begin
			return hi[POS_W-1:0];
		end else if (v < lo) begin
			return lo[POS_W-1:0];
		end
		return v[POS_W-1:0];
	endfunction

endpackage

// ----- rtl/weo_in_if.sv -----
// ----------------------------------------------------------------------------
// Wheel delta input channel
// Valid/ready channel carrying the command and the two wheel deltas.
// ----------------------------------------------------------------------------
interface weo_in_if;
	import weo_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      command;
	logic signed [DELTA_W-1:0] left_delta;
	logic signed [DELTA_W-1:0] right_delta;

	modport source (output valid, output command, output left_delta, output right_delta,
		input ready);
	modport sink (input valid, input command, input left_delta, input right_delta,
		output ready);

endinterface

// ----- rtl/weo_out_if.sv -----
// ----------------------------------------------------------------------------
// Pose output channel
// Valid/ready channel carrying the updated position and heading.
// ----------------------------------------------------------------------------
interface weo_out_if;
	import weo_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic [ANG_W-1:0]        heading_angle;

	modport source (output valid, output pos_x, output pos_y, output heading_angle,
		input ready);
	modport sink (input valid, input pos_x, input pos_y, input heading_angle,
		output ready);

endinterface

// ----- rtl/wheel_encoder_odometry.sv -----
// ----------------------------------------------------------------------------
// Differential-drive wheel odometry
// Integrates left/right wheel deltas into a pose (x, y, heading).
// Input channel in_ch carries command, left_delta and right_delta; command 1
// clears the pose and returns the zero pose. Output channel out_ch returns one
// pose per accepted item. Gains are written through the APB port, at byte 0
// (forward_gain) and byte 4 (turn_gain), and the user must write them only
// while the block is idle; the block does not enforce this. An integrate item
// passes the scale, seed, CORDIC iteration, pose update and result states, the
// shared CORDIC stage doing one rotation step per cycle; a clear item goes
// straight to the result state. The result sits in an output register, so the
// next item is taken while it waits; a stalled receiver only holds a finished
// item in its final state until the output register frees. Reset zeroes the
// pose, loads the default gains and leaves both channels empty.
// ----------------------------------------------------------------------------
`include "wheel_encoder_odometry_macros.svh"

module wheel_encoder_odometry #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [weo_pkg::APB_AW-1:0]  paddr,
	input  logic [weo_pkg::APB_DW-1:0]  pwdata,
	output logic [weo_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	weo_in_if.sink                      in_ch,
	weo_out_if.source                   out_ch
);
	import weo_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;
	pose_t   pose;

	weo_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	weo_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_command (in_ch.command),
		.in_ready   (in_ch.ready),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.status     (status),
		.cmd        (cmd)
	);

	weo_datapath #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.status      (status),
		.left_delta  (in_ch.left_delta),
		.right_delta (in_ch.right_delta),
		.pose_out    (pose)
	);

	assign out_ch.pos_x         = pose.x;
	assign out_ch.pos_y         = pose.y;
	assign out_ch.heading_angle = pose.heading;

	`WEO_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready, "input taken while busy")
	`WEO_ASSERT_NEXT(a_publish_valid, cmd.publish, out_ch.valid, "published result not valid")
	`WEO_ASSERT_NEXT(a_iter_to_accum, cmd.iterate && status.last_iter, cmd.accumulate, "CORDIC end not followed by pose update")
	`WEO_ASSERT_IMP(a_publish_slot_free, cmd.publish, !out_ch.valid || out_ch.ready, "result overwritten before transfer")

endmodule

// ----- rtl/weo_regs.sv -----
// ----------------------------------------------------------------------------
// Odometry configuration registers
// APB write/read of the forward and turn gains; pready is tied high.
// ----------------------------------------------------------------------------
module weo_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [weo_pkg::APB_AW-1:0]   paddr,
	input  logic [weo_pkg::APB_DW-1:0]   pwdata,
	output logic [weo_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	output weo_pkg::cfg_t                cfg
);
	import weo_pkg::*;

	logic [FGAIN_W-1:0] forward_gain_q;
	logic [TGAIN_W-1:0] turn_gain_q;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			forward_gain_q <= FORWARD_GAIN_RST;
			turn_gain_q    <= TURN_GAIN_RST;
		end else if (wr_en) begin
			case (paddr[2])
				REG_FORWARD_GAIN: forward_gain_q <= pwdata[FGAIN_W-1:0];
				REG_TURN_GAIN:    turn_gain_q    <= pwdata[TGAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_FORWARD_GAIN: prdata = {{(APB_DW-FGAIN_W){1'b0}}, forward_gain_q};
			REG_TURN_GAIN:    prdata = turn_gain_q;
			default:          prdata = '0;
		endcase
	end

	assign cfg.forward_gain = forward_gain_q;
	assign cfg.turn_gain    = turn_gain_q;

endmodule

// ----- rtl/weo_ctrl.sv -----
// ----------------------------------------------------------------------------
// Odometry controller
// Sequences scale, CORDIC seed, iterations, pose update and result transfer.
// ----------------------------------------------------------------------------
module weo_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_command,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  weo_pkg::status_t  status,
	output weo_pkg::cmd_t     cmd
);
	import weo_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (in_command) begin
						cmd.clear = 1'b1;
						state_d   = ST_DONE;
					end else begin
						state_d = ST_SCALE;
					end
				end
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = ST_SEED;
			end
			ST_SEED: begin
				cmd.seed = 1'b1;
				state_d  = ST_ITER;
			end
			ST_ITER: begin
				cmd.iterate = 1'b1;
				if (status.last_iter) begin
					state_d = ST_ACCUM;
				end
			end
			ST_ACCUM: begin
				cmd.accumulate = 1'b1;
				state_d        = ST_DONE;
			end
			ST_DONE: begin
				// hold until the output register is free or being drained
				if (!out_valid_q || out_ready) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/weo_datapath.sv -----
// ----------------------------------------------------------------------------
// Odometry datapath
// Gain multipliers, iterative CORDIC, quadrant fix-up and saturating pose.
// ----------------------------------------------------------------------------
module weo_datapath #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  weo_pkg::cfg_t                     cfg,
	input  weo_pkg::cmd_t                     cmd,
	output weo_pkg::status_t                  status,
	input  logic signed [weo_pkg::DELTA_W-1:0] left_delta,
	input  logic signed [weo_pkg::DELTA_W-1:0] right_delta,
	output weo_pkg::pose_t                    pose_out
);
	import weo_pkg::*;

	logic signed [DELTA_W-1:0]    left_q;
	logic signed [DELTA_W-1:0]    right_q;
	logic signed [DELTA_W:0]      sum;
	logic signed [DELTA_W:0]      diff;
	logic signed [FWD_PROD_W-1:0] fwd_prod;
	logic signed [FWD_PROD_W-1:0] fwd_round;
	logic signed [TRN_PROD_W-1:0] trn_prod;
	logic signed [TRN_PROD_W-1:0] dth_round;
	logic signed [TRN_PROD_W-1:0] half_round;

	logic signed [DIST_W-1:0]     dist_q;
	logic [ANG_W-1:0]             dtheta_q;
	logic [ANG_W-1:0]             half_q;

	logic signed [CX_PROD_W-1:0]  cx_prod;
	logic signed [CX_PROD_W-1:0]  cx_shift;
	logic [ANG_W-1:0]             mid;
	logic [ANG_W-1:0]             mid_bias;
	logic [1:0]                   quad;
	logic [ANG_W-1:0]             resid;

	logic signed [CORD_W-1:0]     cx_q;
	logic signed [CORD_W-1:0]     cy_q;
	logic signed [Z_W-1:0]        z_q;
	logic [1:0]                   quad_q;
	logic [CNT_W-1:0]             cnt_q;
	logic signed [CORD_W-1:0]     sx;
	logic signed [CORD_W-1:0]     sy;
	logic signed [Z_W-1:0]        atan_ext;

	logic signed [CORD_W-1:0]     rot_x;
	logic signed [CORD_W-1:0]     rot_y;
	logic signed [SUM_W-1:0]      sum_x;
	logic signed [SUM_W-1:0]      sum_y;

	logic signed [POS_W-1:0]      x_q;
	logic signed [POS_W-1:0]      y_q;
	logic [ANG_W-1:0]             heading_q;
	pose_t                        out_q;

	// scale stage
	assign sum        = (DELTA_W+1)'(left_q) + (DELTA_W+1)'(right_q);
	assign diff       = (DELTA_W+1)'(right_q) - (DELTA_W+1)'(left_q);
	assign fwd_prod   = $signed({1'b0, cfg.forward_gain}) * sum;
	assign fwd_round  = fwd_prod + FWD_PROD_W'(FWD_RND);
	assign trn_prod   = $signed({1'b0, cfg.turn_gain}) * diff;
	assign dth_round  = trn_prod + TRN_PROD_W'(DTHETA_RND);
	assign half_round = trn_prod + TRN_PROD_W'(HALF_RND);

	// seed stage: gain pre-scale and quadrant split of the midpoint heading
	assign cx_prod  = dist_q * INV_GAIN_W'(INV_GAIN);
	assign cx_shift = cx_prod >>> 30;
	assign mid      = heading_q + half_q;
	assign mid_bias = mid + 32'h2000_0000;
	assign quad     = mid_bias[ANG_W-1:ANG_W-2];
	assign resid    = mid - {quad, {(ANG_W-2){1'b0}}};

	// iteration stage
	assign sx       = cx_q >>> cnt_q;
	assign sy       = cy_q >>> cnt_q;
	assign atan_ext = $signed({1'b0, ATAN_TURNS[cnt_q]});

	assign status.last_iter = (cnt_q == CNT_W'(CORDIC_STEPS - 1));

	always_comb begin
		case (quad_q)
			2'd0: begin
				rot_x = cx_q;
				rot_y = cy_q;
			end
			2'd1: begin
				rot_x = -cy_q;
				rot_y = cx_q;
			end
			2'd2: begin
				rot_x = -cx_q;
				rot_y = -cy_q;
			end
			default: begin
				rot_x = cy_q;
				rot_y = -cx_q;
			end
		endcase
	end

	assign sum_x = SUM_W'(x_q) + SUM_W'(rot_x);
	assign sum_y = SUM_W'(y_q) + SUM_W'(rot_y);

	// pose and iteration control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q       <= '0;
			y_q       <= '0;
			heading_q <= '0;
			cnt_q     <= '0;
		end else begin
			if (cmd.clear) begin
				x_q       <= '0;
				y_q       <= '0;
				heading_q <= '0;
			end
			if (cmd.seed) begin
				heading_q <= heading_q + dtheta_q;
				cnt_q     <= '0;
			end
			if (cmd.iterate) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.accumulate) begin
				x_q <= sat_pos(sum_x);
				y_q <= sat_pos(sum_y);
			end
		end
	end

	// operand and working registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			left_q  <= left_delta;
			right_q <= right_delta;
		end
		if (cmd.scale) begin
			dist_q   <= fwd_round[DIST_W+19:20];
			dtheta_q <= dth_round[ANG_W+15:16];
			half_q   <= half_round[ANG_W+16:17];
		end
		if (cmd.seed) begin
			cx_q   <= CORD_W'(cx_shift);
			cy_q   <= '0;
			z_q    <= $signed({resid[ANG_W-1], resid});
			quad_q <= quad;
		end
		if (cmd.iterate) begin
			// non-negative residual rotates counterclockwise
			if (!z_q[Z_W-1]) begin
				cx_q <= cx_q - sy;
				cy_q <= cy_q + sx;
				z_q  <= z_q - atan_ext;
			end else begin
				cx_q <= cx_q + sy;
				cy_q <= cy_q - sx;
				z_q  <= z_q + atan_ext;
			end
		end
		if (cmd.publish) begin
			out_q.x       <= x_q;
			out_q.y       <= y_q;
			out_q.heading <= heading_q;
		end
	end

	assign pose_out = out_q;

endmodule
